// ----- rtl/core/cp2u_pkg.sv -----
package cp2u_pkg;

  // Table geometry.
  localparam int TABLE_ENTRIES = 128;
  localparam int TBL_AW        = $clog2(TABLE_ENTRIES);
  localparam int CP_W          = 21;
  localparam int SEQ_MAX       = 4;
  localparam int SEQ_CW        = $clog2(SEQ_MAX);

  // Input action codes.
  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_CONVERT = 1'b1;

  // Code point range limits for each UTF-8 sequence length.
  localparam logic [CP_W-1:0] CP_MAX_1B = 21'h00007F;
  localparam logic [CP_W-1:0] CP_MAX_2B = 21'h0007FF;
  localparam logic [CP_W-1:0] CP_MAX_3B = 21'h00FFFF;
  localparam logic [CP_W-1:0] CP_MAX_4B = 21'h10FFFF;

  // Lead and continuation byte prefixes, plus substitutes.
  localparam logic [7:0] LEAD_2B   = 8'hC0;
  localparam logic [7:0] LEAD_3B   = 8'hE0;
  localparam logic [7:0] LEAD_4B   = 8'hF0;
  localparam logic [7:0] CONT_BYTE = 8'h80;
  localparam logic [7:0] SUB_NULL  = 8'h20;
  localparam logic [7:0] SUB_RANGE = 8'h7E;

  // Remaining-byte counts (bytes left minus one) per sequence length.
  localparam logic [SEQ_CW-1:0] REM_1B = 2'd0;
  localparam logic [SEQ_CW-1:0] REM_2B = 2'd1;
  localparam logic [SEQ_CW-1:0] REM_3B = 2'd2;
  localparam logic [SEQ_CW-1:0] REM_4B = 2'd3;

  typedef struct packed {
    logic            action;
    logic [TBL_AW-1:0] entry_index;
    logic [CP_W-1:0] code_point;
    logic [7:0]      data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

endpackage

// ----- rtl/core/cp2u_ram.sv -----
// Simple dual-port RAM with one write port and one registered read port.
module cp2u_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // The read data holds whenever no read is issued.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/codepage_to_utf8_converter.sv -----
// An accepted byte is registered in the lookup stage, then moves to the output serializer.
// Throughput: one output byte per cycle while out_stall is low; a convert transaction
// yields one to four bytes, set by its UTF-8 length, and a load only writes the table.
// The table lives in a 128 x 21 RAM read in the cycle a high byte is accepted.
// Reset clears the pipeline valid bits only; the table is undefined until loaded.
module codepage_to_utf8_converter import cp2u_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic              in_accept;
  logic              cvt_accept;
  logic              tbl_wr;
  logic              tbl_rd;
  logic [CP_W-1:0]   tbl_q;

  logic              s1_valid_r, s1_valid_nxt;
  logic [7:0]        s1_byte_r, s1_byte_nxt;
  logic              s1_adv;

  logic              ser_valid_r, ser_valid_nxt;
  logic [7:0]        seq_r   [SEQ_MAX];
  logic [7:0]        seq_nxt [SEQ_MAX];
  logic [SEQ_CW-1:0] rem_r, rem_nxt;
  logic              ser_free;
  logic              out_accept;

  logic [7:0]        enc_seq [SEQ_MAX];
  logic [SEQ_CW-1:0] enc_rem;
  logic [CP_W-1:0]   cp;

  // Input handshake: loads write the table, high bytes read it.
  assign in_accept  = in_valid & ~in_stall;
  assign cvt_accept = in_accept & (in_data.action == ACT_CONVERT);
  assign tbl_wr     = in_accept & (in_data.action == ACT_LOAD);
  assign tbl_rd     = cvt_accept & in_data.data_byte[7];

  cp2u_ram #(
    .WIDTH (CP_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr),
    .wr_addr (in_data.entry_index),
    .wr_data (in_data.code_point),
    .rd_en   (tbl_rd),
    .rd_addr (in_data.data_byte[TBL_AW-1:0]),
    .rd_data (tbl_q)
  );

  // The serializer frees up when it is empty or its last byte leaves now.
  assign out_accept = out_valid & ~out_stall;
  assign ser_free   = ~ser_valid_r | (out_accept & (rem_r == REM_1B));
  assign s1_adv     = s1_valid_r & ser_free;
  assign in_stall   = s1_valid_r & ~ser_free;

  // Lookup stage; the RAM output holds while this stage is stalled.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_byte_nxt  = s1_byte_r;
    if (!s1_valid_r || s1_adv) begin
      s1_valid_nxt = cvt_accept;
      s1_byte_nxt  = in_data.data_byte;
    end
  end

  // Encode the byte or the looked-up code point into a UTF-8 sequence.
  always_comb begin
    cp = tbl_q;
    for (int i = 0; i < SEQ_MAX; i++) begin
      enc_seq[i] = CONT_BYTE;
    end
    enc_rem = REM_1B;
    if (!s1_byte_r[7]) begin
      enc_seq[0] = s1_byte_r;
    end else if (cp == '0) begin
      enc_seq[0] = SUB_NULL;
    end else if (cp <= CP_MAX_1B) begin
      enc_seq[0] = cp[7:0];
    end else if (cp <= CP_MAX_2B) begin
      enc_seq[0] = LEAD_2B | {3'b000, cp[10:6]};
      enc_seq[1] = CONT_BYTE | {2'b00, cp[5:0]};
      enc_rem    = REM_2B;
    end else if (cp <= CP_MAX_3B) begin
      enc_seq[0] = LEAD_3B | {4'b0000, cp[15:12]};
      enc_seq[1] = CONT_BYTE | {2'b00, cp[11:6]};
      enc_seq[2] = CONT_BYTE | {2'b00, cp[5:0]};
      enc_rem    = REM_3B;
    end else if (cp <= CP_MAX_4B) begin
      enc_seq[0] = LEAD_4B | {5'b00000, cp[20:18]};
      enc_seq[1] = CONT_BYTE | {2'b00, cp[17:12]};
      enc_seq[2] = CONT_BYTE | {2'b00, cp[11:6]};
      enc_seq[3] = CONT_BYTE | {2'b00, cp[5:0]};
      enc_rem    = REM_4B;
    end else begin
      enc_seq[0] = SUB_RANGE;
    end
  end

  // Output serializer: loads a whole sequence, then shifts one byte out per transaction.
  always_comb begin
    ser_valid_nxt = ser_valid_r;
    rem_nxt       = rem_r;
    for (int i = 0; i < SEQ_MAX; i++) begin
      seq_nxt[i] = seq_r[i];
    end
    if (s1_adv) begin
      ser_valid_nxt = 1'b1;
      rem_nxt       = enc_rem;
      for (int i = 0; i < SEQ_MAX; i++) begin
        seq_nxt[i] = enc_seq[i];
      end
    end else if (out_accept) begin
      if (rem_r == REM_1B) begin
        ser_valid_nxt = 1'b0;
      end else begin
        rem_nxt = rem_r - SEQ_CW'(1);
        for (int i = 0; i < SEQ_MAX - 1; i++) begin
          seq_nxt[i] = seq_r[i+1];
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      ser_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      ser_valid_r <= ser_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    s1_byte_r <= s1_byte_nxt;
    rem_r     <= rem_nxt;
    for (int i = 0; i < SEQ_MAX; i++) begin
      seq_r[i] <= seq_nxt[i];
    end
  end

  assign out_valid         = ser_valid_r;
  assign out_data.out_byte = seq_r[0];
  assign out_data.last     = (rem_r == REM_1B);

  // The input side only stalls while a lookup result is waiting.
  a_stall_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("input stalled with an empty lookup stage");

  // A convert transaction always reaches the lookup stage.
  a_cvt_enters_s1: assert property (@(posedge clk) disable iff (!rst_n)
    cvt_accept |=> s1_valid_r)
    else $error("accepted convert transaction was lost");

  // A sequence never ends before its last byte is taken.
  a_seq_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_accept && !out_data.last |=> out_valid)
    else $error("UTF-8 sequence cut short");

endmodule

// ----- tb/codepage_to_utf8_converter_tb.sv -----
module codepage_to_utf8_converter_tb;
  import cp2u_pkg::*;

  localparam int RANDOM_ITEMS = 445;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int PRINT_LIMIT  = 50;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Stimulus and the expected byte stream.
  in_item_t  pending_items[$];
  out_item_t utf8_expected[$];

  // Predictor state: the code point table as the block should hold it.
  logic [CP_W-1:0] cp_table_model [TABLE_ENTRIES];

  // Generation side bookkeeping, so no unloaded entry is ever converted.
  bit entry_loaded [TABLE_ENTRIES];
  int loaded_list[$];

  int   errors = 0;
  int   items_total = 0;
  int   items_accepted = 0;
  int   gap_left = 0;
  int   stall_left = 0;
  int   cycle_cnt = 0;
  bit   in_taken;
  logic hold_long = 1'b0;

  codepage_to_utf8_converter DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Clock with a 10 unit period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mismatch reporting; printing is capped but every failure is counted.
  task automatic report_mismatch(input string msg);
    if (errors < PRINT_LIMIT) begin
      $display("MISMATCH at cycle %0d: %s", cycle_cnt, msg);
    end
    errors++;
  endtask

  // Random delay: mostly none, some short, a few long.
  function automatic int pick_delay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else if (r < 98) return $urandom_range(4, 12);
    else return $urandom_range(25, 50);
  endfunction

  // Periodic windows in which neither side idles.
  function automatic bit quiet_window();
    return (cycle_cnt % 1000) < 150;
  endfunction

  // Random code point spread over every encoding class.
  function automatic logic [CP_W-1:0] pick_code_point();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return CP_W'($urandom_range(1, 'h7F));
      2: return CP_W'($urandom_range('h80, 'h7FF));
      3: return CP_W'($urandom_range('h800, 'hFFFF));
      4: return CP_W'($urandom_range('h10000, 'h10FFFF));
      5: return CP_W'($urandom_range('h110000, 'h1FFFFF));
      default: return CP_W'($urandom);
    endcase
  endfunction

  task automatic queue_load(input int idx, input logic [CP_W-1:0] cp);
    in_item_t t;
    t.action      = ACT_LOAD;
    t.entry_index = idx[TBL_AW-1:0];
    t.code_point  = cp;
    t.data_byte   = 8'($urandom);
    pending_items.push_back(t);
    if (!entry_loaded[idx]) begin
      entry_loaded[idx] = 1'b1;
      loaded_list.push_back(idx);
    end
  endtask

  task automatic queue_convert(input logic [7:0] b);
    in_item_t t;
    t.action      = ACT_CONVERT;
    t.entry_index = TBL_AW'($urandom);
    t.code_point  = CP_W'($urandom);
    t.data_byte   = b;
    pending_items.push_back(t);
  endtask

  task automatic push_utf8_byte(input logic [7:0] b, input logic is_last);
    out_item_t e;
    e.out_byte = b;
    e.last     = is_last;
    utf8_expected.push_back(e);
  endtask

  // Predictor: apply one accepted transaction and queue the UTF-8 bytes it yields.
  task automatic predict_utf8(input in_item_t t);
    logic [CP_W-1:0] cp;
    if (t.action == ACT_LOAD) begin
      cp_table_model[t.entry_index] = t.code_point;
    end else if (!t.data_byte[7]) begin
      push_utf8_byte(t.data_byte, 1'b1);
    end else begin
      cp = cp_table_model[t.data_byte[6:0]];
      if (cp == '0) begin
        push_utf8_byte(SUB_NULL, 1'b1);
      end else if (cp <= CP_MAX_1B) begin
        push_utf8_byte(cp[7:0], 1'b1);
      end else if (cp <= CP_MAX_2B) begin
        push_utf8_byte(LEAD_2B | {3'b000, cp[10:6]}, 1'b0);
        push_utf8_byte(CONT_BYTE | {2'b00, cp[5:0]}, 1'b1);
      end else if (cp <= CP_MAX_3B) begin
        push_utf8_byte(LEAD_3B | {4'b0000, cp[15:12]}, 1'b0);
        push_utf8_byte(CONT_BYTE | {2'b00, cp[11:6]}, 1'b0);
        push_utf8_byte(CONT_BYTE | {2'b00, cp[5:0]}, 1'b1);
      end else if (cp <= CP_MAX_4B) begin
        push_utf8_byte(LEAD_4B | {5'b00000, cp[20:18]}, 1'b0);
        push_utf8_byte(CONT_BYTE | {2'b00, cp[17:12]}, 1'b0);
        push_utf8_byte(CONT_BYTE | {2'b00, cp[11:6]}, 1'b0);
        push_utf8_byte(CONT_BYTE | {2'b00, cp[5:0]}, 1'b1);
      end else begin
        push_utf8_byte(SUB_RANGE, 1'b1);
      end
    end
  endtask

  // Driver: record accepted transactions and present the next pending item.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      in_taken = in_valid && !in_stall;
      if (in_taken) begin
        predict_utf8(in_data);
        items_accepted++;
      end
      if (!in_valid || in_taken) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_data  <= pending_items.pop_front();
          in_valid <= 1'b1;
          gap_left = quiet_window() ? 0 : pick_delay();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted output byte and drive the receiver stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (utf8_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h last %0b",
                                    out_data.out_byte, out_data.last));
        end else begin
          if (out_data.out_byte !== utf8_expected[0].out_byte) begin
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      out_data.out_byte, utf8_expected[0].out_byte));
          end
          if (out_data.last !== utf8_expected[0].last) begin
            report_mismatch($sformatf("last %0b, expected %0b",
                                      out_data.last, utf8_expected[0].last));
          end
          void'(utf8_expected.pop_front());
        end
      end
      if (hold_long) begin
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = quiet_window() ? 0 : pick_delay();
      end
    end
  end

  // Cycle count and timeout.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Long receiver hold-off while the sender keeps offering, to back up the block.
  initial begin
    while (items_accepted < 150) @(posedge clk);
    hold_long <= 1'b1;
    repeat (80) @(posedge clk);
    hold_long <= 1'b0;
  end

  // Stimulus generation, reset and end of run.
  initial begin
    int idx;
    int r;

    // Directed: table entries at each encoding class boundary, both index extremes.
    queue_load(0,   21'h000000);
    queue_load(1,   21'h000001);
    queue_load(2,   21'h00007F);
    queue_load(3,   21'h000080);
    queue_load(4,   21'h0007FF);
    queue_load(5,   21'h000800);
    queue_load(6,   21'h00FFFF);
    queue_load(7,   21'h00D800);
    queue_load(8,   21'h010000);
    queue_load(9,   21'h10FFFF);
    queue_load(10,  21'h110000);
    queue_load(127, 21'h1FFFFF);
    // Pass-through extremes, then every loaded entry.
    queue_convert(8'h00);
    queue_convert(8'h7F);
    for (int i = 0; i <= 10; i++) queue_convert(8'(8'h80 + i));
    queue_convert(8'hFF);

    // Random: mostly conversions of loaded entries, with reloads and ASCII mixed in.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        queue_load($urandom_range(0, TABLE_ENTRIES - 1), pick_code_point());
      end else if (r < 50) begin
        queue_convert(8'($urandom_range(0, 127)));
      end else begin
        idx = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
        queue_convert(8'(8'h80 + idx));
      end
    end
    items_total = pending_items.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (items_accepted < items_total) @(posedge clk);
    while (utf8_expected.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- codepage_to_utf8_converter.f -----
rtl/core/cp2u_pkg.sv
rtl/core/cp2u_ram.sv
rtl/core/codepage_to_utf8_converter.sv
tb/codepage_to_utf8_converter_tb.sv
